FILE: hdl/dpalu_pkg.sv
// shared types and codes for the data-processing alu
package dpalu_pkg;

  // data-processing opcodes
  localparam logic [3:0] OP_SUB = 4'd2;
  localparam logic [3:0] OP_ADD = 4'd4;
  localparam logic [3:0] OP_TST = 4'd8;
  localparam logic [3:0] OP_TEQ = 4'd9;
  localparam logic [3:0] OP_CMP = 4'd10;
  localparam logic [3:0] OP_ORR = 4'd12;
  localparam logic [3:0] OP_MOV = 4'd13;
  localparam logic [3:0] OP_BIC = 4'd14;

  // shift types
  localparam logic [1:0] SH_LSL = 2'd0;
  localparam logic [1:0] SH_LSR = 2'd1;
  localparam logic [1:0] SH_ASR = 2'd2;
  localparam logic [1:0] SH_ROR = 2'd3;

  // flag bit positions
  localparam int FLAG_N = 3;
  localparam int FLAG_Z = 2;
  localparam int FLAG_C = 1;
  localparam int FLAG_V = 0;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [31:0] operand_n;
    logic [31:0] operand_m;
    logic        imm_mode;
    logic [1:0]  shift_type;
    logic [7:0]  shift_amount;
    logic        shift_by_reg;
    logic        set_flags;
    logic        dest_is_pc;
    logic [3:0]  flags_in;
  } dpalu_in_t;

  typedef struct packed {
    logic [31:0] result;
    logic        write_result;
    logic [3:0]  flags_out;
    logic        flags_written;
    logic        flush;
    logic        extra_cycle;
  } dpalu_out_t;

  // control that rides along the pipeline
  typedef struct packed {
    logic [3:0] opcode;
    logic       set_flags;
    logic       dest_is_pc;
    logic [3:0] flags_in;
    logic       extra_cycle;
  } dpalu_ctl_t;

  // after the shifter stage
  typedef struct packed {
    dpalu_ctl_t  ctl;
    logic [31:0] operand_n;
    logic [31:0] op2;
    logic        sh_carry;
  } dpalu_shf_t;

  // after the alu stage
  typedef struct packed {
    dpalu_ctl_t  ctl;
    logic [31:0] res;
    logic        c;
    logic        v;
    logic        impl;
    logic        wr;
  } dpalu_alu_t;

endpackage

FILE: hdl/dpalu_shifter.sv
// stage 1: second operand barrel shifter with registered output
module dpalu_shifter
  import dpalu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       valid_in,
  input  dpalu_in_t  item_in,
  output logic       valid_out,
  output dpalu_shf_t shf_out
);

  logic        valid_r;
  dpalu_shf_t  shf_r;
  dpalu_shf_t  shf_nxt;

  logic [31:0] v;
  logic [7:0]  amt;
  logic        c_old;
  logic        msb;
  logic        amt_zero;
  logic        amt_lt32;
  logic        amt_is32;
  logic [32:0] lsl_w;
  logic [32:0] lsr_w;
  logic signed [32:0] asr_w;
  logic [63:0] rot_w;
  logic [63:0] imm_w;
  logic [31:0] op2;
  logic        sc;

  assign v        = item_in.operand_m;
  // immediate shifts use five bits, register shifts the whole byte
  assign amt      = item_in.shift_by_reg ? item_in.shift_amount
                                         : {3'd0, item_in.shift_amount[4:0]};
  assign c_old    = item_in.flags_in[FLAG_C];
  assign msb      = v[31];
  assign amt_zero = (amt == 8'd0);
  assign amt_lt32 = (amt < 8'd32);
  assign amt_is32 = (amt == 8'd32);

  assign lsl_w = {1'b0, v} << amt[4:0];
  assign lsr_w = {v, 1'b0} >> amt[4:0];
  assign asr_w = $signed({v, 1'b0}) >>> amt[4:0];
  assign rot_w = {v, v} >> amt[4:0];
  assign imm_w = {24'd0, v[7:0], 24'd0, v[7:0]} >> {item_in.shift_amount[3:0], 1'b0};

  always_comb begin
    op2 = v;
    sc  = c_old;
    if (item_in.imm_mode) begin
      op2 = imm_w[31:0];
    end else if (item_in.shift_by_reg && amt_zero) begin
      op2 = v;
    end else begin
      case (item_in.shift_type)
        SH_LSL: begin
          if (amt_zero) begin
            op2 = v;
          end else if (amt_lt32) begin
            op2 = lsl_w[31:0];
            sc  = lsl_w[32];
          end else begin
            op2 = 32'd0;
            sc  = amt_is32 ? v[0] : 1'b0;
          end
        end
        SH_LSR: begin
          if (amt_zero || amt_is32) begin
            op2 = 32'd0;
            sc  = msb;
          end else if (amt_lt32) begin
            op2 = lsr_w[32:1];
            sc  = lsr_w[0];
          end else begin
            op2 = 32'd0;
            sc  = 1'b0;
          end
        end
        SH_ASR: begin
          if (amt_zero || !amt_lt32) begin
            op2 = {32{msb}};
            sc  = msb;
          end else begin
            op2 = asr_w[32:1];
            sc  = asr_w[0];
          end
        end
        SH_ROR: begin
          if (amt_zero) begin
            // rrx
            op2 = {c_old, v[31:1]};
            sc  = v[0];
          end else if (amt[4:0] == 5'd0) begin
            op2 = v;
            sc  = msb;
          end else begin
            op2 = rot_w[31:0];
            sc  = rot_w[31];
          end
        end
        default: begin
          op2 = v;
          sc  = c_old;
        end
      endcase
    end
  end

  always_comb begin
    shf_nxt.ctl.opcode      = item_in.opcode;
    shf_nxt.ctl.set_flags   = item_in.set_flags;
    shf_nxt.ctl.dest_is_pc  = item_in.dest_is_pc;
    shf_nxt.ctl.flags_in    = item_in.flags_in;
    shf_nxt.ctl.extra_cycle = !item_in.imm_mode && item_in.shift_by_reg;
    shf_nxt.operand_n       = item_in.operand_n;
    shf_nxt.op2             = op2;
    shf_nxt.sh_carry        = sc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_in) begin
      shf_r <= shf_nxt;
    end
  end

  assign valid_out = valid_r;
  assign shf_out   = shf_r;

endmodule

FILE: hdl/dpalu_exec.sv
// stage 2: add, subtract and logic operations with registered output
module dpalu_exec
  import dpalu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       valid_in,
  input  dpalu_shf_t shf_in,
  output logic       valid_out,
  output dpalu_alu_t alu_out
);

  logic        valid_r;
  dpalu_alu_t  alu_r;
  dpalu_alu_t  alu_nxt;

  logic [31:0] rn;
  logic [31:0] op2;
  logic [32:0] add_w;
  logic [32:0] sub_w;
  logic        c_old;
  logic        v_old;

  assign rn    = shf_in.operand_n;
  assign op2   = shf_in.op2;
  assign add_w = {1'b0, rn} + {1'b0, op2};
  assign sub_w = {1'b0, rn} - {1'b0, op2};
  assign c_old = shf_in.ctl.flags_in[FLAG_C];
  assign v_old = shf_in.ctl.flags_in[FLAG_V];

  always_comb begin
    alu_nxt.ctl  = shf_in.ctl;
    alu_nxt.res  = 32'd0;
    alu_nxt.c    = c_old;
    alu_nxt.v    = v_old;
    alu_nxt.impl = 1'b1;
    alu_nxt.wr   = 1'b0;
    case (shf_in.ctl.opcode)
      OP_SUB, OP_CMP: begin
        alu_nxt.res = sub_w[31:0];
        alu_nxt.c   = !sub_w[32];
        alu_nxt.v   = (rn[31] ^ op2[31]) & (rn[31] ^ sub_w[31]);
        alu_nxt.wr  = (shf_in.ctl.opcode == OP_SUB);
      end
      OP_ADD: begin
        alu_nxt.res = add_w[31:0];
        alu_nxt.c   = add_w[32];
        alu_nxt.v   = ~(rn[31] ^ op2[31]) & (rn[31] ^ add_w[31]);
        alu_nxt.wr  = 1'b1;
      end
      // logic ops take the shifter carry and keep v
      OP_TST: begin
        alu_nxt.res = rn & op2;
        alu_nxt.c   = shf_in.sh_carry;
      end
      OP_TEQ: begin
        alu_nxt.res = rn ^ op2;
        alu_nxt.c   = shf_in.sh_carry;
      end
      OP_ORR: begin
        alu_nxt.res = rn | op2;
        alu_nxt.c   = shf_in.sh_carry;
        alu_nxt.wr  = 1'b1;
      end
      OP_MOV: begin
        alu_nxt.res = op2;
        alu_nxt.c   = shf_in.sh_carry;
        alu_nxt.wr  = 1'b1;
      end
      OP_BIC: begin
        alu_nxt.res = rn & ~op2;
        alu_nxt.c   = shf_in.sh_carry;
        alu_nxt.wr  = 1'b1;
      end
      default: begin
        alu_nxt.impl = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_in) begin
      alu_r <= alu_nxt;
    end
  end

  assign valid_out = valid_r;
  assign alu_out   = alu_r;

endmodule

FILE: hdl/arm_data_processing_alu.sv
// top level of the data-processing alu: shifter, alu and flag stages
//
//   channel   handshake            payload     beat taken when
//   input     start / busy         in_item     start high, busy low
//   result    out_valid (strobe)   out_item    the cycle out_valid is high
//
// one beat may enter every cycle
// the pipeline has three register stages: shifter, alu, flag/output
// busy is held low: the pipeline never stalls and the receiver cannot stall it
// rst_n is synchronous, active low, and clears the stage valid bits only
// payload registers load only when their stage holds a valid beat
module arm_data_processing_alu
  import dpalu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  dpalu_in_t  in_item,
  output logic       out_valid,
  output dpalu_out_t out_item
);

  // stage wiring
  logic       shf_valid;
  dpalu_shf_t shf_data;
  logic       alu_valid;
  dpalu_alu_t alu_data;

  // output stage
  logic       out_valid_r;
  dpalu_out_t out_item_r;
  dpalu_out_t out_item_nxt;

  logic       accept;
  logic       upd_flags;

  // never stalls
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stage 1: barrel shifter / rotated immediate
  dpalu_shifter u_shifter (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (accept),
    .item_in   (in_item),
    .valid_out (shf_valid),
    .shf_out   (shf_data)
  );

  // stage 2: arithmetic and logic
  dpalu_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (shf_valid),
    .shf_in    (shf_data),
    .valid_out (alu_valid),
    .alu_out   (alu_data)
  );

  // stage 3: flag update, flush and write enable
  // s set with a pc destination keeps the flags and asks for a flush
  assign upd_flags = alu_data.impl && alu_data.ctl.set_flags && !alu_data.ctl.dest_is_pc;

  always_comb begin
    out_item_nxt.result        = alu_data.res;
    out_item_nxt.write_result  = alu_data.wr;
    out_item_nxt.flags_out     = alu_data.ctl.flags_in;
    if (upd_flags) begin
      out_item_nxt.flags_out[FLAG_N] = alu_data.res[31];
      out_item_nxt.flags_out[FLAG_Z] = (alu_data.res == 32'd0);
      out_item_nxt.flags_out[FLAG_C] = alu_data.c;
      out_item_nxt.flags_out[FLAG_V] = alu_data.v;
    end
    out_item_nxt.flags_written = upd_flags;
    out_item_nxt.flush         = alu_data.impl && alu_data.ctl.set_flags &&
                                 alu_data.ctl.dest_is_pc;
    out_item_nxt.extra_cycle   = alu_data.ctl.extra_cycle;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= alu_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (alu_valid) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  // every result beat comes from an earlier accepted input beat
  a_out_from_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 3))
    else $error("result beat without a matching input beat");

  // flush only for an s-bit operation aimed at the pc
  a_flush_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.flush) |->
      $past(in_item.set_flags && in_item.dest_is_pc, 3))
    else $error("flush without s bit and pc destination");

  // extra cycle only for register-specified shifts
  a_extra_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.extra_cycle) |->
      $past(!in_item.imm_mode && in_item.shift_by_reg, 3))
    else $error("extra cycle flagged for a non register shift");

  // flush and flag write never come together
  a_flush_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.flush && out_item.flags_written))
    else $error("flush and flag write on the same beat");
`endif

endmodule
